// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");
// implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/atd_pkg.sv -----
// ----------------------------------------------------------------------------
// atd_pkg
// Shared constants and tables of the affine decomposition block.
// ----------------------------------------------------------------------------
package atd_pkg;

	localparam int ELEMENT_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF     = 16;
	localparam int CFG_W             = 16;
	localparam int OUT_W             = 32;
	localparam int ANGLE_W           = 19;
	localparam int OUT_TDATA_W       = 256;
	localparam int CORDIC_STEPS      = 28;
	localparam int CORDIC_W          = 34;
	localparam int ZACC_W            = 35;
	localparam int ANG_FRAC          = 30;
	localparam int NORM_CNT          = 7;
	localparam logic [ZACC_W-1:0] PI_Q30 = 35'd3373259426;

	// atan(2^-i) in Q2.30
	function automatic logic [30:0] atd_atan(input logic [4:0] i);
		logic [30:0] r;
		case (i)
			5'd0:    r = 31'd843314857;
			5'd1:    r = 31'd497837829;
			5'd2:    r = 31'd263043837;
			5'd3:    r = 31'd133525159;
			5'd4:    r = 31'd67021687;
			5'd5:    r = 31'd33543516;
			5'd6:    r = 31'd16775851;
			5'd7:    r = 31'd8388437;
			5'd8:    r = 31'd4194283;
			5'd9:    r = 31'd2097149;
			default: r = (i < 5'd28) ? (31'd1 << (5'd30 - i)) : 31'd0;
		endcase
		return r;
	endfunction

	// matrix element normalized in each divide slot: n00 n01 n02 n11 n12 n20 n22
	function automatic logic [3:0] atd_norm_elem(input logic [2:0] t);
		logic [3:0] r;
		case (t)
			3'd0:    r = 4'd0;
			3'd1:    r = 4'd1;
			3'd2:    r = 4'd2;
			3'd3:    r = 4'd5;
			3'd4:    r = 4'd6;
			3'd5:    r = 4'd8;
			3'd6:    r = 4'd10;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/affine_transform_decompose.sv -----
// ----------------------------------------------------------------------------
// affine_transform_decompose
// 4x4 transform decomposition into translation, Euler angles and scale.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis: one request per matrix element; tdata = {value, index}, index in
//  the low 4 bits; tlast marks the element that starts decomposition.
//  Elements are stored column-major (column*4 + row) and persist between
//  matrices, so only changed elements need to be resent.
//  m_axis: one result per tlast request; tuser = ok, tdata packed below.
//  cfg_we/cfg_wdata: w_zero_threshold, write only while idle.
// Sequence:
//  A plain element is only stored. A tlast request gets a threshold check then,
//  if accepted: 3 column lengths (multiply/add steps and a sqrt each), up to
//  7 divides of NW-bit quotients (NW = ELEMENT_WIDTH+FRAC_BITS), one more
//  square and sqrt, and up to 3 CORDIC runs; the divider dominates.
//  s_axis_tready is low from tlast acceptance until the result is taken.
// Reset: matrix cleared to zero, threshold set to 1, block idle.
// Stall: the result holds on m_axis until m_axis_tready; no new request is
//  taken meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module affine_transform_decompose #(
	parameter int ELEMENT_WIDTH = atd_pkg::ELEMENT_WIDTH_DEF,
	parameter int FRAC_BITS     = atd_pkg::FRAC_BITS_DEF,
	localparam int IN_W         = ((4 + ELEMENT_WIDTH + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [atd_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// element_index [3:0], element_value [ELEMENT_WIDTH+3:4], zero fill
	input  logic [IN_W-1:0]                     s_axis_tdata,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// trans_x, trans_y, trans_z (32 each), angle_x, angle_y, angle_z (19 each),
	// scale_x, scale_y, scale_z (32 each), zero fill
	output logic [atd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// ok
	output logic                                m_axis_tuser
);
	import atd_pkg::*;

	localparam int EW   = ELEMENT_WIDTH;
	localparam int FB   = FRAC_BITS;
	localparam int SQ_W = (2 * EW > 2 * FB + 2) ? 2 * EW : 2 * FB + 2;
	localparam int MW   = SQ_W / 2;
	localparam int LW   = EW + 1;
	localparam int NW   = EW + FB;
	localparam int VW   = FB + 2;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_MUL    = 4'd2;
	localparam logic [3:0] S_ACC    = 4'd3;
	localparam logic [3:0] S_SQRT   = 4'd4;
	localparam logic [3:0] S_NORM   = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_CSTART = 4'd7;
	localparam logic [3:0] S_CORD   = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	localparam logic PH_LEN  = 1'b0;
	localparam logic PH_ASIN = 1'b1;

	localparam logic signed [VW-1:0] ONE_V = VW'(1) <<< FB;

	logic [3:0]              state_q;
	logic                    phase_q;
	logic [1:0]              col_q, term_q, ang_q;
	logic [2:0]              nidx_q;
	logic [CFG_W-1:0]        thr_q;
	logic [EW-1:0]           store_q [16];
	logic [SQ_W-1:0]         acc_q;
	logic [SQ_W-1:0]         prod_q;
	logic [LW-1:0]           len_q [3];
	logic [FB:0]             c_q;
	logic signed [VW-1:0]    n_q [NORM_CNT];
	logic signed [ANGLE_W-1:0] ang_res_q [3];
	logic                    ok_q;

	logic                    in_acc;
	logic [3:0]              rd_idx;
	logic [EW-1:0]           rd_val;
	logic [EW-1:0]           rd_mag;
	logic [EW-1:0]           w_mag;
	logic [MW-1:0]           mul_op;
	logic [SQ_W-1:0]         radicand;
	logic [3:0]              norm_elem;
	logic [LW-1:0]           len_sel;
	logic [NW-1:0]           div_num;
	logic [NW-1:0]           q_sat;
	logic signed [VW-1:0]    n_val;
	logic                    gimbal;
	logic signed [VW-1:0]    cy, cx;
	logic                    sq_start, sq_done;
	logic [SQ_W/2:0]         sq_root;
	logic                    div_start, div_done;
	logic [NW-1:0]           div_quot;
	logic                    cord_start, cord_done;
	logic signed [ANGLE_W-1:0] cord_angle;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);

	// read port on the element store, shared by the multiply and normalize steps
	assign norm_elem = atd_norm_elem(nidx_q);
	assign rd_idx    = (state_q == S_MUL) ? {col_q, term_q} : norm_elem;
	assign rd_val    = store_q[rd_idx];
	assign rd_mag    = rd_val[EW-1] ? EW'(-signed'(rd_val)) : rd_val;
	assign w_mag     = store_q[15][EW-1] ? EW'(-signed'(store_q[15])) : store_q[15];

	// squares: element magnitudes for lengths, |n02| for the asin cosine
	assign mul_op   = (phase_q == PH_ASIN) ?
		MW'(n_q[2][VW-1] ? -n_q[2] : n_q[2]) : MW'(rd_mag);
	assign radicand = (phase_q == PH_ASIN) ?
		((SQ_W'(1) << (2 * FB)) - prod_q) : (acc_q + prod_q);

	assign len_sel = len_q[norm_elem[3:2]];
	assign div_num = (NW'(rd_mag) << FB) + NW'(len_sel >> 1);
	assign q_sat   = (div_quot > NW'(ONE_V)) ? NW'(ONE_V) : div_quot;
	assign n_val   = rd_val[EW-1] ? -signed'(VW'(q_sat)) : signed'(VW'(q_sat));

	assign gimbal = (n_q[2] == ONE_V) || (n_q[2] == -ONE_V);

	always_comb begin
		case (ang_q)
			2'd0: begin
				cy = -n_q[2];
				cx = signed'(VW'(c_q));
			end
			2'd1: begin
				cy = gimbal ? -n_q[5] : n_q[4];
				cx = gimbal ? n_q[3] : n_q[6];
			end
			default: begin
				cy = n_q[1];
				cx = n_q[0];
			end
		endcase
	end

	assign sq_start   = (state_q == S_ACC) && (phase_q == PH_ASIN || term_q == 2'd2);
	assign div_start  = (state_q == S_NORM) && (len_sel != '0);
	assign cord_start = (state_q == S_CSTART) && !(ang_q == 2'd2 && gimbal);

	atd_sqrt #(.W(SQ_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .rad(radicand),
		.done(sq_done), .root(sq_root)
	);

	atd_div #(.NW(NW), .DW(LW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(len_sel), .done(div_done), .quot(div_quot)
	);

	atd_cordic #(.FB(FB)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start), .y(cy), .x(cx),
		.done(cord_done), .angle(cord_angle)
	);

	// element store and threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 16; k++) begin
				store_q[k] <= '0;
			end
			thr_q <= CFG_W'(1);
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (in_acc) begin
				store_q[s_axis_tdata[3:0]] <= s_axis_tdata[EW+3:4];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_LEN;
			col_q   <= '0;
			term_q  <= '0;
			nidx_q  <= '0;
			ang_q   <= '0;
			ok_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && s_axis_tlast) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					phase_q <= PH_LEN;
					col_q   <= '0;
					term_q  <= '0;
					nidx_q  <= '0;
					ang_q   <= '0;
					if (w_mag < EW'(thr_q)) begin
						ok_q    <= 1'b0;
						state_q <= S_OUT;
					end else begin
						ok_q    <= 1'b1;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (sq_start) begin
						state_q <= S_SQRT;
					end else begin
						term_q  <= term_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						if (phase_q == PH_ASIN) begin
							state_q <= S_CSTART;
						end else if (col_q == 2'd2) begin
							state_q <= S_NORM;
						end else begin
							col_q   <= col_q + 1'b1;
							term_q  <= '0;
							state_q <= S_MUL;
						end
					end
				end
				S_NORM: begin
					if (div_start) begin
						state_q <= S_DIV;
					end else if (nidx_q == 3'(NORM_CNT - 1)) begin
						phase_q <= PH_ASIN;
						state_q <= S_MUL;
					end else begin
						nidx_q <= nidx_q + 1'b1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (nidx_q == 3'(NORM_CNT - 1)) begin
							phase_q <= PH_ASIN;
							state_q <= S_MUL;
						end else begin
							nidx_q  <= nidx_q + 1'b1;
							state_q <= S_NORM;
						end
					end
				end
				S_CSTART: begin
					state_q <= cord_start ? S_CORD : S_OUT;
				end
				S_CORD: begin
					if (cord_done) begin
						if (ang_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							ang_q   <= ang_q + 1'b1;
							state_q <= S_CSTART;
						end
					end
				end
				S_OUT: begin
					if (m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK || (state_q == S_SQRT && sq_done)) begin
			acc_q <= '0;
		end else if (state_q == S_ACC) begin
			acc_q <= acc_q + prod_q;
		end
		if (state_q == S_MUL) begin
			prod_q <= SQ_W'(mul_op * mul_op);
		end
		if (state_q == S_SQRT && sq_done) begin
			if (phase_q == PH_ASIN) begin
				c_q <= (FB+1)'(sq_root);
			end else begin
				len_q[col_q] <= LW'(sq_root);
			end
		end
		if (state_q == S_NORM && !div_start) begin
			n_q[nidx_q] <= '0;
		end else if (state_q == S_DIV && div_done) begin
			n_q[nidx_q] <= n_val;
		end
		if (state_q == S_CSTART && !cord_start) begin
			ang_res_q[2] <= '0;
		end else if (state_q == S_CORD && cord_done) begin
			ang_res_q[ang_q] <= cord_angle;
		end
	end

	// result packing; a rejected matrix reports zeros
	always_comb begin
		m_axis_tdata = '0;
		if (ok_q) begin
			m_axis_tdata[31:0]    = OUT_W'(signed'(store_q[12]));
			m_axis_tdata[63:32]   = OUT_W'(signed'(store_q[13]));
			m_axis_tdata[95:64]   = OUT_W'(signed'(store_q[14]));
			m_axis_tdata[114:96]  = ang_res_q[1];
			m_axis_tdata[133:115] = ang_res_q[0];
			m_axis_tdata[152:134] = ang_res_q[2];
			m_axis_tdata[184:153] = OUT_W'(len_q[0]);
			m_axis_tdata[216:185] = OUT_W'(len_q[1]);
			m_axis_tdata[248:217] = OUT_W'(len_q[2]);
		end
	end
	assign m_axis_tuser = ok_q;

	// shared units only report completion in the state waiting for them
	`ASSERT_IMPL(a_sqrt_done_state, clk, arst_n, sq_done, state_q == S_SQRT)
	`ASSERT_IMPL(a_div_done_state, clk, arst_n, div_done, state_q == S_DIV)
	`ASSERT_IMPL(a_cord_done_state, clk, arst_n, cord_done, state_q == S_CORD)
	`ASSERT_CLK(a_no_accept_with_result, clk, arst_n, !(m_axis_tvalid && s_axis_tready))

endmodule

// ----- hdl/atd_sqrt.sv -----
// ----------------------------------------------------------------------------
// atd_sqrt
// Bit-serial integer square root, two radicand bits per cycle, rounded.
// ----------------------------------------------------------------------------
module atd_sqrt #(
	parameter int W = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   rad,
	output logic           done,
	output logic [W/2:0]   root
);
	localparam int HW = W / 2;
	localparam int CW = $clog2(HW + 1);

	logic [W-1:0]  rad_q;
	logic [HW:0]   rem_q;
	logic [HW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [HW+2:0] r;
	logic [HW+2:0] trial;
	logic          ge;

	assign r     = {rem_q, rad_q[W-1:W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (r >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(HW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[W-3:0], 2'b00};
			rem_q  <= ge ? (HW+1)'(r - trial) : (HW+1)'(r);
			root_q <= {root_q[HW-2:0], ge};
		end
	end

	// round to nearest: remainder above root means the next integer is closer
	assign done = done_q;
	assign root = (rem_q > {1'b0, root_q}) ? ({1'b0, root_q} + 1'b1) : {1'b0, root_q};

endmodule

// ----- hdl/atd_div.sv -----
// ----------------------------------------------------------------------------
// atd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atd_div #(
	parameter int NW = 48,
	parameter int DW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   r;
	logic          ge;

	assign r  = {rem_q, num_q[NW-1]};
	assign ge = (r >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(r - {1'b0, den_q}) : DW'(r);
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ----- hdl/atd_cordic.sv -----
// ----------------------------------------------------------------------------
// atd_cordic
// Vectoring CORDIC atan2, one micro-rotation per cycle, Q2.30 internally.
// ----------------------------------------------------------------------------
module atd_cordic #(
	parameter int FB = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [FB+1:0]                 y,
	input  logic signed [FB+1:0]                 x,
	output logic                                 done,
	output logic signed [atd_pkg::ANGLE_W-1:0]   angle
);
	import atd_pkg::*;

	localparam int SH = ANG_FRAC - FB;

	logic signed [CORDIC_W-1:0] x_q, y_q, sx, sy, x0, y0;
	logic signed [ZACC_W-1:0]   z_q;
	logic [4:0]                 i_q;
	logic                       busy_q;
	logic                       done_q;
	logic [ZACC_W-1:0]          zmag;
	logic [ZACC_W-1:0]          zrnd;
	logic [ZACC_W-1:0]          atan_v;

	// arithmetic shift that truncates toward zero
	function automatic logic signed [CORDIC_W-1:0] f_sra(
		input logic signed [CORDIC_W-1:0] v, input logic [4:0] s);
		logic signed [CORDIC_W-1:0] m;
		m = v[CORDIC_W-1] ? -v : v;
		m = m >>> s;
		return v[CORDIC_W-1] ? -m : m;
	endfunction

	assign x0     = CORDIC_W'(x) <<< SH;
	assign y0     = CORDIC_W'(y) <<< SH;
	assign sx     = f_sra(x_q, i_q);
	assign sy     = f_sra(y_q, i_q);
	assign atan_v = ZACC_W'(atd_atan(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				i_q <= '0;
				if (x == '0 && y == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (i_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (x == '0 && y == '0) begin
				z_q <= '0;
			end else if (x[FB+1]) begin
				// left half-plane: rotate by pi first
				x_q <= -x0;
				y_q <= -y0;
				z_q <= y[FB+1] ? -signed'(PI_Q30) : signed'(PI_Q30);
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (!y_q[CORDIC_W-1]) begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + signed'(atan_v);
			end else begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - signed'(atan_v);
			end
		end
	end

	// Q2.30 to output scale, half away from zero
	assign zmag  = z_q[ZACC_W-1] ? ZACC_W'(-z_q) : ZACC_W'(z_q);
	assign zrnd  = (zmag + (ZACC_W'(1) << (SH - 1))) >> SH;
	assign angle = z_q[ZACC_W-1] ? ANGLE_W'(-signed'(zrnd)) : ANGLE_W'(zrnd);
	assign done  = done_q;

endmodule
